>>> rtl/core/pmcr_pkg.sv
// ----------------------------------------------------------------------------
// pmcr_pkg
// Shared types and constants for the premultiplied mip chain reducer.
// ----------------------------------------------------------------------------
package pmcr_pkg;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] REG_SIDE_LOG2    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLUSTER_LOG2 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PREMULTIPLY  = 2'd2;

    localparam logic [3:0] SIDE_LOG2_RST    = 4'd12;
    localparam logic [3:0] CLUSTER_LOG2_RST = 4'd6;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } t_pix;

endpackage

>>> rtl/core/pmcr_ram.sv
// ----------------------------------------------------------------------------
// pmcr_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pmcr_ram #(
    parameter int unsigned WIDTH = 27,
    parameter int unsigned DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/premultiplied_mip_chain_reducer.sv
// ----------------------------------------------------------------------------
// premultiplied_mip_chain_reducer
// Optionally premultiplies RGBA pixels and emits the 2x2 box-filtered mip chain.
// ----------------------------------------------------------------------------
// channel   direction  content
// s_axis    in         pixel: tdata = red, green, blue, alpha
// m_axis    out        result: tdata = out_red, out_green, out_blue;
//                      tuser = level; tlast = final result of the pixel
// cfg       in         register write: side_log2, cluster_log2, premultiply
//
// A pixel passes two entry stages (premultiply product, divide by 255) and
// then the level walker. The walker emits one result per cycle while it is
// not stalled, and for each 2x2 block it completes it waits on the pair-sum
// RAM read before it emits the next level's result. Pixels that end at
// level 0 stream one per cycle while not stalled. The walker stalls while
// the output register is full and not taken; the next pixel waits in the entry stages.
// Reset clears counters and control; the row store is not cleared.
// ----------------------------------------------------------------------------
module premultiplied_mip_chain_reducer #(
    parameter int unsigned MAX_SIDE_LOG2 = 12,
    parameter int unsigned MAX_LEVELS    = 6
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // red, green, blue, alpha
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // out_red, out_green, out_blue
    output logic [2:0]  m_axis_tuser,   // level
    output logic        m_axis_tlast,
    input  logic        i_cfg_we,
    input  logic [pmcr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pmcr_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int unsigned NLEV  = MAX_LEVELS + 1;
    localparam int unsigned LW    = (NLEV > 1) ? $clog2(NLEV) : 1;
    localparam int unsigned CW    = MAX_SIDE_LOG2;
    localparam int unsigned DEPTH = 1 << MAX_SIDE_LOG2;
    localparam int unsigned AW    = MAX_SIDE_LOG2;

    // configuration
    logic [3:0] r_side_log2, r_cluster_log2;
    logic       r_premul;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side_log2    <= pmcr_pkg::SIDE_LOG2_RST;
            r_cluster_log2 <= pmcr_pkg::CLUSTER_LOG2_RST;
            r_premul       <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pmcr_pkg::REG_SIDE_LOG2:    r_side_log2    <= i_cfg_data;
                pmcr_pkg::REG_CLUSTER_LOG2: r_cluster_log2 <= i_cfg_data;
                pmcr_pkg::REG_PREMULTIPLY:  r_premul       <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    logic [3:0] s_eff;
    logic [3:0] red_cnt;
    assign s_eff = (r_side_log2 > 4'(MAX_SIDE_LOG2)) ? 4'(MAX_SIDE_LOG2) : r_side_log2;
    always_comb begin
        red_cnt = (s_eff > r_cluster_log2) ? (s_eff - r_cluster_log2) : 4'd0;
        if (red_cnt > 4'(MAX_LEVELS)) begin
            red_cnt = 4'(MAX_LEVELS);
        end
    end

    // stage 1: premultiply product register
    logic        r_p1_v;
    logic [15:0] r_pr, r_pg, r_pb;
    logic        r_p1_pm;

    // stage 2: pixel entering the level walker
    logic            r_p2_v;
    pmcr_pkg::t_pix  r_p2_pix;

    // level walker
    logic            r_busy;      // a pixel is in the walker
    logic            r_wait;      // waiting on a row store read
    logic [LW-1:0]   r_lvl;
    pmcr_pkg::t_pix  r_cur;
    logic [8:0]      r_sr, r_sg, r_sb;  // pair sums awaiting the store read

    // per-level counters and even pixel
    logic [CW-1:0]   r_col [NLEV];
    logic [CW-1:0]   r_row [NLEV];
    pmcr_pkg::t_pix  r_even [NLEV];

    // output register
    logic            r_o_v;
    pmcr_pkg::t_pix  r_o_pix;
    logic [2:0]      r_o_lvl;
    logic            r_o_last;

    // ram
    logic            ram_we;
    logic [AW-1:0]   ram_waddr, ram_raddr;
    logic [26:0]     ram_wdata, ram_rdata;

    pmcr_ram #(.WIDTH(27), .DEPTH(DEPTH)) u_rows (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // walker step logic
    logic [3:0]    sk;
    logic [CW-1:0] mask, cc, yy, cn, yn;
    logic          step_fire;      // walker emits a result this cycle
    logic          can_emit;
    logic          reduce, odd_c, odd_y, more;
    logic [8:0]    pr9, pg9, pb9;
    logic [AW:0]   full, base;
    pmcr_pkg::t_pix avg;
    logic [10:0]   ar, ag, ab;

    assign can_emit = !r_o_v || m_axis_tready;

    always_comb begin
        sk    = s_eff - 4'(r_lvl);
        mask  = CW'(({{CW{1'b0}}, 1'b1} << sk) - 1'b1);
        cc    = r_col[r_lvl] & mask;
        yy    = r_row[r_lvl] & mask;
        reduce = {1'b0, r_lvl} < (LW+1)'(red_cnt);
        odd_c = cc[0];
        odd_y = yy[0];
        more  = reduce && odd_c && odd_y;
        pr9   = {1'b0, r_even[r_lvl].r} + {1'b0, r_cur.r};
        pg9   = {1'b0, r_even[r_lvl].g} + {1'b0, r_cur.g};
        pb9   = {1'b0, r_even[r_lvl].b} + {1'b0, r_cur.b};
        full  = (AW+1)'(1) << s_eff;
        base  = full - (full >> r_lvl);
        cn    = (cc + 1'b1) & mask;
        yn    = (cn == '0) ? ((yy + 1'b1) & mask) : yy;
        ar    = {2'b0, ram_rdata[26:18]} + {2'b0, r_sr};
        ag    = {2'b0, ram_rdata[17:9]}  + {2'b0, r_sg};
        ab    = {2'b0, ram_rdata[8:0]}   + {2'b0, r_sb};
        avg.r = ar[9:2];
        avg.g = ag[9:2];
        avg.b = ab[9:2];
    end

    assign step_fire = r_busy && !r_wait && can_emit;
    assign ram_raddr = AW'(base + (AW+1)'(cc >> 1));
    assign ram_waddr = ram_raddr;
    assign ram_wdata = {pr9, pg9, pb9};
    assign ram_we    = step_fire && reduce && odd_c && !odd_y;

    // premultiply divide by 255: q = (p + 1 + (p >> 8)) >> 8 exact for p <= 65025
    function automatic logic [7:0] div255(input logic [15:0] p);
        logic [16:0] t;
        t = {1'b0, p} + 17'd1 + {9'd0, p[15:8]};
        return t[15:8];
    endfunction

    // stage 2 holds while the walker is busy, until it emits its final result
    logic p2_take;
    assign p2_take  = r_p2_v && (!r_busy || (step_fire && !more));
    assign s_axis_tready = !r_p1_v || !r_p2_v || p2_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v <= 1'b0;
            r_p2_v <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_p1_v <= s_axis_tvalid;
            end
            if (r_p1_v && (!r_p2_v || p2_take)) begin
                r_p2_v <= 1'b1;
            end else if (p2_take) begin
                r_p2_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready) begin
            r_p1_pm <= r_premul;
            r_pr <= 16'(s_axis_tdata[7:0])   * (r_premul ? 16'(s_axis_tdata[31:24]) : 16'd1);
            r_pg <= 16'(s_axis_tdata[15:8])  * (r_premul ? 16'(s_axis_tdata[31:24]) : 16'd1);
            r_pb <= 16'(s_axis_tdata[23:16]) * (r_premul ? 16'(s_axis_tdata[31:24]) : 16'd1);
        end
        if (r_p1_v && (!r_p2_v || p2_take)) begin
            r_p2_pix.r <= r_p1_pm ? div255(r_pr) : r_pr[7:0];
            r_p2_pix.g <= r_p1_pm ? div255(r_pg) : r_pg[7:0];
            r_p2_pix.b <= r_p1_pm ? div255(r_pb) : r_pb[7:0];
        end
    end

    // walker
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_wait <= 1'b0;
            r_lvl  <= '0;
            for (int i = 0; i < NLEV; i++) begin
                r_col[i] <= '0;
                r_row[i] <= '0;
            end
        end else begin
            if (r_wait) begin
                r_wait <= 1'b0;
                r_cur  <= avg;
            end else if (step_fire) begin
                r_col[r_lvl] <= cn;
                r_row[r_lvl] <= yn;
                if (reduce && !odd_c) begin
                    r_even[r_lvl] <= r_cur;
                end
                if (more) begin
                    r_wait <= 1'b1;
                    r_lvl  <= r_lvl + 1'b1;
                    r_sr   <= pr9;
                    r_sg   <= pg9;
                    r_sb   <= pb9;
                end else begin
                    r_busy <= 1'b0;
                end
            end
            if (p2_take) begin
                r_busy <= 1'b1;
                r_lvl  <= '0;
                r_cur  <= r_p2_pix;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (step_fire) begin
            r_o_v <= 1'b1;
        end else if (m_axis_tready) begin
            r_o_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_fire) begin
            r_o_pix  <= r_cur;
            r_o_lvl  <= 3'(r_lvl);
            r_o_last <= !more;
        end
    end

    assign m_axis_tvalid = r_o_v;
    assign m_axis_tdata  = {r_o_pix.b, r_o_pix.g, r_o_pix.r};
    assign m_axis_tuser  = r_o_lvl;
    assign m_axis_tlast  = r_o_last;

endmodule
